// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/xs64_pkg.sv =====
package xs64_pkg;

    localparam logic [63:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL_A    = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_B    = 64'h94d049bb133111eb;
    localparam logic [63:0] STAR_MUL     = 64'd2685821657736338717;
    localparam logic [63:0] STATE_RESET  = 64'h853c49e6748fea9b;

    localparam int PROD_W = 96;

    typedef enum logic {
        OP_RESEED = 1'b0,
        OP_DRAW   = 1'b1
    } op_t;

    // classified item as it sits in the front queue
    typedef struct packed {
        op_t         op;
        logic [63:0] seed;
        logic [31:0] low;
        logic [31:0] span;      // high - low, valid when not inverted
        logic        inverted;  // low > high
    } q_item_t;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } mul_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] product;
    } mul_rsp_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MIX_A,
        BK_MIX_B,
        BK_STAR,
        BK_SCALE,
        BK_WB
    } bk_state_t;

endpackage

// ===== rtl/xs64_mul.sv =====
// 64x64 multiply on one 32x32 multiplier: three partial products, 96-bit sum.
// Gives the low 64 bits of any product and the exact product when a[63:32] is 0.
module xs64_mul
    import xs64_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    typedef enum logic [1:0] {
        MS_LL,
        MS_LH,
        MS_HL
    } mul_step_t;

    logic [63:0]       a_reg, b_reg;
    mul_step_t         step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              pv_reg, last_reg, done_reg;
    logic              sh_reg, sh_next;
    logic [63:0]       prod_reg, prod_next;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [31:0]       mul_a, mul_b;

    always_comb
    begin
        unique case (step_reg)
            MS_LH:
            begin
                mul_a   = a_reg[31:0];
                mul_b   = b_reg[63:32];
                sh_next = 1'b1;
            end
            MS_HL:
            begin
                mul_a   = a_reg[63:32];
                mul_b   = b_reg[31:0];
                sh_next = 1'b1;
            end
            default:
            begin
                mul_a   = a_reg[31:0];
                mul_b   = b_reg[31:0];
                sh_next = 1'b0;
            end
        endcase
        prod_next = mul_a * mul_b;
        acc_next  = acc_reg + (sh_reg ? {prod_reg, 32'd0} : {32'd0, prod_reg});
    end

    always_comb
    begin
        step_next = step_reg;
        busy_next = busy_reg;
        if (req.start)
        begin
            step_next = MS_LL;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            unique case (step_reg)
                MS_LL:   step_next = MS_LH;
                MS_LH:   step_next = MS_HL;
                default: busy_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= MS_LL;
            busy_reg <= 1'b0;
            pv_reg   <= 1'b0;
            last_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            pv_reg   <= busy_reg && !req.start;
            last_reg <= busy_reg && !req.start && (step_reg == MS_HL);
            done_reg <= pv_reg && last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            acc_reg <= '0;
        end
        else if (pv_reg)
        begin
            acc_reg <= acc_next;
        end
        prod_reg <= prod_next;
        sh_reg   <= sh_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule

// ===== rtl/xs64_front.sv =====
// Accepts items, classifies them (operation, range span, inverted range)
// and holds them in a small queue for the back end.
module xs64_front
    import xs64_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               kind,
    input  logic        [63:0] seed,
    input  logic signed [31:0] low_bound,
    input  logic signed [31:0] high_bound,
    output logic               q_valid,
    output q_item_t            q_item,
    input  logic               q_pop
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    q_item_t        mem_reg [DEPTH];
    q_item_t        cls_item;
    logic [IW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [IW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [32:0]    diff;
    logic           wr;

    always_comb
    begin
        diff              = {high_bound[31], high_bound} - {low_bound[31], low_bound};
        cls_item.op       = kind ? OP_DRAW : OP_RESEED;
        cls_item.seed     = seed;
        cls_item.low      = low_bound;
        cls_item.span     = diff[31:0];
        cls_item.inverted = diff[32];
    end

    assign full    = (count_reg == CW'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = mem_reg[rd_ptr_reg];
    assign wr      = push && !full;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr)
        begin
            wr_ptr_next = (wr_ptr_reg == IW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == IW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wr_ptr_reg] <= cls_item;
        end
    end

endmodule

// ===== rtl/xs64_back.sv =====
// Executes queued items: splitmix64 reseed, xorshift64* draw and range
// scaling, all through the shared multiplier. Owns the result register.
module xs64_back
    import xs64_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  q_item_t            q_item,
    output logic               q_pop,
    output mul_req_t           mul_req,
    input  mul_rsp_t           mul_rsp,
    input  logic               pop,
    output logic               empty,
    output logic signed [31:0] value,
    output logic               range_error
);

    function automatic logic [63:0] xs_step(input logic [63:0] s);
        logic [63:0] x;
        x = s ^ (s >> 12);
        x = x ^ (x << 25);
        x = x ^ (x >> 27);
        return x;
    endfunction

    bk_state_t   st_reg, st_next;
    logic [63:0] gen_reg, gen_next;
    logic [31:0] lo_reg, lo_next;
    logic [31:0] span_reg, span_next;
    logic        inv_reg, inv_next;
    logic [31:0] res_value_reg, res_value_next;
    logic        res_err_reg, res_err_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_value_reg, out_value_next;
    logic        out_err_reg, out_err_next;

    logic [63:0] z0, t0, z1, u1, s2, x_adv;
    logic [52:0] r53;
    logic [31:0] q32;
    logic        wb_go;

    always_comb
    begin
        z0    = q_item.seed + GOLDEN_GAMMA;
        t0    = z0 ^ (z0 >> 30);
        z1    = mul_rsp.product[63:0];
        u1    = z1 ^ (z1 >> 27);
        s2    = z1 ^ (z1 >> 31);
        x_adv = xs_step(gen_reg);
        r53   = mul_rsp.product[63:11];
        q32   = mul_rsp.product[84:53];
        wb_go = !out_valid_reg || pop;
    end

    // next state
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    st_next = (q_item.op == OP_RESEED) ? BK_MIX_A : BK_STAR;
                end
            end
            BK_MIX_A:
            begin
                if (mul_rsp.done)
                begin
                    st_next = BK_MIX_B;
                end
            end
            BK_MIX_B:
            begin
                if (mul_rsp.done)
                begin
                    st_next = BK_IDLE;
                end
            end
            BK_STAR:
            begin
                if (mul_rsp.done)
                begin
                    st_next = inv_reg ? BK_WB : BK_SCALE;
                end
            end
            BK_SCALE:
            begin
                if (mul_rsp.done)
                begin
                    st_next = BK_WB;
                end
            end
            BK_WB:
            begin
                if (wb_go)
                begin
                    st_next = BK_IDLE;
                end
            end
            default: st_next = BK_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        q_pop          = 1'b0;
        mul_req.start  = 1'b0;
        mul_req.a      = t0;
        mul_req.b      = MIX_MUL_A;
        gen_next       = gen_reg;
        lo_next        = lo_reg;
        span_next      = span_reg;
        inv_next       = inv_reg;
        res_value_next = res_value_reg;
        res_err_next   = res_err_reg;
        out_value_next = out_value_reg;
        out_err_next   = out_err_reg;
        out_valid_next = out_valid_reg && !pop;
        unique case (st_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop         = 1'b1;
                    mul_req.start = 1'b1;
                    if (q_item.op == OP_DRAW)
                    begin
                        mul_req.a = x_adv;
                        mul_req.b = STAR_MUL;
                        gen_next  = x_adv;
                        lo_next   = q_item.low;
                        span_next = q_item.span;
                        inv_next  = q_item.inverted;
                    end
                end
            end
            BK_MIX_A:
            begin
                mul_req.a = u1;
                mul_req.b = MIX_MUL_B;
                if (mul_rsp.done)
                begin
                    mul_req.start = 1'b1;
                end
            end
            BK_MIX_B:
            begin
                if (mul_rsp.done)
                begin
                    gen_next = (s2 == '0) ? GOLDEN_GAMMA : s2;
                end
            end
            BK_STAR:
            begin
                mul_req.a = {32'd0, span_reg};
                mul_req.b = {11'd0, r53};
                if (mul_rsp.done)
                begin
                    if (inv_reg)
                    begin
                        res_value_next = lo_reg;
                        res_err_next   = 1'b1;
                    end
                    else
                    begin
                        mul_req.start = 1'b1;
                    end
                end
            end
            BK_SCALE:
            begin
                if (mul_rsp.done)
                begin
                    res_value_next = lo_reg + q32;
                    res_err_next   = 1'b0;
                end
            end
            BK_WB:
            begin
                if (wb_go)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_value_reg;
                    out_err_next   = res_err_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= BK_IDLE;
            gen_reg       <= STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            gen_reg       <= gen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg        <= lo_next;
        span_reg      <= span_next;
        inv_reg       <= inv_next;
        res_value_reg <= res_value_next;
        res_err_reg   <= res_err_next;
        out_value_reg <= out_value_next;
        out_err_reg   <= out_err_next;
    end

    assign empty       = !out_valid_reg;
    assign value       = signed'(out_value_reg);
    assign range_error = out_err_reg;

endmodule

// ===== rtl/xorshift64star_uniform_range.sv =====
// Uniform integer source: a 64-bit xorshift64* generator (shifts 12, 25, 27,
// output multiplier 2685821657736338717, top 53 bits kept) seeded through
// splitmix64. kind = 0 reseeds: the state becomes splitmix64(seed), or the
// golden-ratio constant if that comes out zero; zero is an ordinary seed and
// a reseed gives no result. kind = 1 draws: the state advances and one result
// comes back, value = low_bound + floor((high_bound - low_bound) * r / 2^53),
// computed exactly, so it lies in [low_bound, high_bound) and equals low_bound
// for an empty range. With low_bound > high_bound the state still advances,
// value is low_bound and range_error is 1. After reset the state is
// 0x853c49e6748fea9b. Both sides look like a queue: push/full in, empty/pop
// out. Up to QUEUE_DEPTH items wait ahead of the execution unit and one result
// waits in the output register, so input is still taken while a result sits
// unread. Every 64-bit product runs through one shared 32x32 multiplier,
// which sets the pace. The execution unit takes one item at a time: a reseed
// holds it for two products, a draw for two (one when the range is inverted).
module xorshift64star_uniform_range
    import xs64_pkg::*;
#(
    // items buffered between front and back end, 2 to 32
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    // item side
    input  logic               push,
    output logic               full,
    input  logic               kind,
    input  logic        [63:0] seed,
    input  logic signed [31:0] low_bound,
    input  logic signed [31:0] high_bound,
    // result side
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] value,
    output logic               range_error
);

    logic     q_valid;
    logic     q_pop;
    q_item_t  q_item;
    mul_req_t mul_req;
    mul_rsp_t mul_rsp;

    // front end: accept, classify, queue
    xs64_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .kind       (kind),
        .seed       (seed),
        .low_bound  (low_bound),
        .high_bound (high_bound),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    // back end: generator state, sequencing, result register
    xs64_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .mul_req     (mul_req),
        .mul_rsp     (mul_rsp),
        .pop         (pop),
        .empty       (empty),
        .value       (value),
        .range_error (range_error)
    );

    // shared multiplier for splitmix64 mixing, the star product and scaling
    xs64_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

endmodule

// ===== rtl/xs64_chk.sv =====
`include "assert_macros.svh"

module xs64_chk (
    input logic               clk,
    input logic               rst_n,
    input logic               push,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input logic signed [31:0] value,
    input logic               range_error
);

    // a waiting result stays put until taken
    `ASSERT_NEXT(a_result_hold, clk, rst_n, !empty && !pop, !empty && $stable(value) && $stable(range_error))

    // the queue only fills through an accepted item
    `ASSERT_NOW(a_full_by_push, clk, rst_n, $rose(full), $past(push && !full))

    // the result register only drains through a pop
    `ASSERT_NOW(a_empty_by_pop, clk, rst_n, $rose(empty), $past(pop))

endmodule

bind xorshift64star_uniform_range xs64_chk u_chk (.*);

// ===== tb/xorshift64star_uniform_range_tb.sv =====
module xorshift64star_uniform_range_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import xs64_pkg::*;

    // run shape
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 1630;
    localparam int QUIET_ITEMS  = 150;   // tail of the run with no gaps on either side
    localparam int HOLD_AT      = 400;   // items accepted before the long result-side stall
    localparam int HOLD_CYCLES  = 120;
    localparam int STALL_LIMIT  = 2000;  // cycles with no handshake before giving up
    localparam int DRAIN_CYCLES = 40;    // wait after the last expected result for any stray one
    localparam int MAX_REPORTS  = 10;

    localparam logic [31:0] INT_MIN = 32'h8000_0000;
    localparam logic [31:0] INT_MAX = 32'h7fff_ffff;

    // splitmix64 only returns zero when seed + gamma wraps to zero
    localparam logic [63:0] ZERO_MIX_SEED = 64'd0 - GOLDEN_GAMMA;

    typedef struct {
        op_t         op;
        logic [63:0] seed;
        logic [31:0] lo;
        logic [31:0] hi;
        bit          typed;       // expected result written out by hand
        logic [31:0] want_value;
        bit          want_error;
    } stim_t;

    typedef struct {
        logic [31:0] value;
        logic        error;
    } draw_t;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               push       = 1'b0;
    logic               full;
    logic               kind       = 1'b0;
    logic        [63:0] seed       = '0;
    logic signed [31:0] low_bound  = '0;
    logic signed [31:0] high_bound = '0;
    logic               empty;
    logic               pop        = 1'b0;
    logic signed [31:0] value;
    logic               range_error;

    // predictor state and bookkeeping
    logic [63:0] rng_state = STATE_RESET;
    draw_t       draws_due[$];
    stim_t       directed_rows[$];
    int          items_in  = 0;
    int          failures  = 0;
    int          results_seen = 0;
    bit          no_gaps   = 1'b0;

    xorshift64star_uniform_range u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .kind        (kind),
        .seed        (seed),
        .low_bound   (low_bound),
        .high_bound  (high_bound),
        .empty       (empty),
        .pop         (pop),
        .value       (value),
        .range_error (range_error)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // splitmix64 finalizer, 64-bit wrapping arithmetic throughout
    function automatic logic [63:0] splitmix64(input logic [63:0] s);
        logic [63:0] z;
        z = s + GOLDEN_GAMMA;
        z = (z ^ (z >> 30)) * MIX_MUL_A;
        z = (z ^ (z >> 27)) * MIX_MUL_B;
        return z ^ (z >> 31);
    endfunction

    // Advance the xorshift state, then scale the top 53 bits of the starred
    // state onto [lo, hi). The scaling is the exact floor of span * r / 2^53,
    // done here as one wide product.
    function automatic draw_t draw_from(input logic [31:0] lo, input logic [31:0] hi);
        logic [63:0] x;
        logic [63:0] starred;
        logic [52:0] r;
        logic [32:0] span;
        logic [85:0] scaled;
        draw_t       res;
        x = rng_state;
        x ^= x >> 12;
        x ^= x << 25;
        x ^= x >> 27;
        rng_state = x;
        starred = x * STAR_MUL;
        r = starred[63:11];
        if ($signed(lo) > $signed(hi))
        begin
            // inverted range: state still moves, bound comes back flagged
            res.value = lo;
            res.error = 1'b1;
        end
        else
        begin
            span   = {hi[31], hi} - {lo[31], lo};   // 0 .. 2^32-1
            scaled = span[31:0] * r;
            res.value = lo + scaled[84:53];
            res.error = 1'b0;
        end
        return res;
    endfunction

    // Update the predictor with one accepted item; a draw queues its result.
    task automatic model_item(input stim_t it);
        draw_t want;
        if (it.op == OP_RESEED)
        begin
            rng_state = splitmix64(it.seed);
            if (rng_state == '0)
                rng_state = GOLDEN_GAMMA;
        end
        else
        begin
            want = draw_from(it.lo, it.hi);
            if (it.typed)
            begin
                want.value = it.want_value;
                want.error = it.want_error;
            end
            draws_due.push_back(want);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic void add_row(input op_t op, input logic [63:0] s,
                                    input logic [31:0] lo, input logic [31:0] hi,
                                    input bit typed = 1'b0,
                                    input logic [31:0] v = '0, input bit e = 1'b0);
        stim_t row;
        row.op         = op;
        row.seed       = s;
        row.lo         = lo;
        row.hi         = hi;
        row.typed      = typed;
        row.want_value = v;
        row.want_error = e;
        directed_rows.push_back(row);
    endfunction

    // Mostly ordinary draws over random ranges; some reseeds, inverted,
    // empty, narrow and full-width ranges mixed in.
    function automatic stim_t make_random_item();
        stim_t       it;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] tmp;
        int          mode;
        it.typed      = 1'b0;
        it.want_value = '0;
        it.want_error = 1'b0;
        it.seed       = {$urandom, $urandom};
        a = $urandom;
        b = $urandom;
        it.op = ($urandom_range(0, 99) < 12) ? OP_RESEED : OP_DRAW;
        mode = $urandom_range(0, 9);
        case (mode)
            0:
            begin
                if ($signed(a) < $signed(b))
                begin
                    tmp = a;
                    a   = b;
                    b   = tmp;
                end
            end
            1: b = a;
            2: b = a + $urandom_range(1, 64);    // may wrap into an inverted range
            3:
            begin
                a = INT_MIN;
                b = INT_MAX;
            end
            default:
            begin
                if ($signed(a) > $signed(b))
                begin
                    tmp = a;
                    a   = b;
                    b   = tmp;
                end
            end
        endcase
        it.lo = a;
        it.hi = b;
        return it;
    endfunction

    // Sender gap: now and then push drops low before the next item, skipped in the quiet tail.
    task automatic maybe_gap();
        int n;
        if (!no_gaps && $urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 9);
            @(negedge clk) push <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // Drive at the falling edge, then wait for the edge that takes the item.
    // push stays high into the next item if there is no gap.
    task automatic offer_item(input stim_t it);
        @(negedge clk);
        push       <= 1'b1;
        kind       <= it.op;
        seed       <= it.seed;
        low_bound  <= it.lo;
        high_bound <= it.hi;
        do @(posedge clk); while (full !== 1'b0);
        model_item(it);
        items_in++;
    endtask

    task automatic flag_mismatch(input string what, input int want, input int got);
        failures++;
        if (failures <= MAX_REPORTS)
            $display("result %0d: %s expected %0d, got %0d", results_seen, what, want, got);
    endtask

    // ------------------------------------------------------------------
    // Result checker: every popped item against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        draw_t want;
        if (rst_n && pop && !empty)
        begin
            if (draws_due.size() == 0)
            begin
                flag_mismatch("unexpected result, value", 0, value);
            end
            else
            begin
                want = draws_due.pop_front();
                if (value !== want.value)
                    flag_mismatch("value", $signed(want.value), value);
                if (range_error !== want.error)
                    flag_mismatch("range_error", want.error, range_error);
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------
    // Result side: random pop bursts, one long stall to back the block up
    // ------------------------------------------------------------------
    initial
    begin : result_side
        int n;
        bit held;
        held = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (!held && items_in >= HOLD_AT)
            begin
                // sender keeps offering, so queue and output register fill
                held = 1'b1;
                @(negedge clk) pop <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (!no_gaps && $urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 9);
                @(negedge clk) pop <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            else
            begin
                n = $urandom_range(1, 12);
                @(negedge clk) pop <= 1'b1;
                repeat (n - 1) @(negedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any handshake means a hang
    // ------------------------------------------------------------------
    initial
    begin : watchdog
        int stalled;
        stalled = 0;
        wait (rst_n === 1'b1);
        while (stalled < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                stalled = 0;
            else
                stalled++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        stim_t it;

        // directed rows; hand-written expectations only where obvious
        add_row(OP_DRAW,   '0, 32'd0, 32'd100);                    // first draw from reset state
        add_row(OP_DRAW,   '0, INT_MIN, INT_MAX);                  // widest range
        add_row(OP_DRAW,   '0, 32'd5, 32'd5, 1'b1, 32'd5, 1'b0);   // empty range
        add_row(OP_DRAW,   '0, INT_MAX, INT_MIN, 1'b1, INT_MAX, 1'b1); // inverted, extremes
        add_row(OP_DRAW,   '0, 32'd1, 32'd0, 1'b1, 32'd1, 1'b1);   // inverted by one
        add_row(OP_DRAW,   '0, INT_MIN, INT_MIN, 1'b1, INT_MIN, 1'b0);
        add_row(OP_DRAW,   '0, INT_MAX, INT_MAX, 1'b1, INT_MAX, 1'b0);
        add_row(OP_DRAW,   '0, -32'sd1, 32'd0, 1'b1, -32'sd1, 1'b0); // unit range gives low
        add_row(OP_RESEED, '0, 32'd0, 32'd0);                      // zero is a plain seed
        add_row(OP_DRAW,   '0, 32'd0, 32'd1000);
        add_row(OP_RESEED, ZERO_MIX_SEED, 32'd0, 32'd0);           // mix yields zero -> gamma
        add_row(OP_DRAW,   '0, INT_MIN, INT_MAX);
        add_row(OP_DRAW,   '0, -32'sd10, 32'd10);
        add_row(OP_RESEED, '1, INT_MAX, INT_MIN);
        add_row(OP_DRAW,   '0, 32'd0, INT_MAX);
        add_row(OP_DRAW,   '0, INT_MIN, 32'd0);
        add_row(OP_RESEED, 64'h8000_0000_0000_0000, 32'd0, 32'd0);
        add_row(OP_DRAW,   '0, -32'sd1, -32'sd2, 1'b1, -32'sd1, 1'b1);
        add_row(OP_DRAW,   '1, INT_MIN, INT_MAX);
        add_row(OP_RESEED, 64'h0123_4567_89ab_cdef, 32'd0, 32'd0);
        add_row(OP_DRAW,   '0, -32'sd1000, -32'sd1);
        add_row(OP_DRAW,   '0, 32'd0, 32'd0, 1'b1, 32'd0, 1'b0);

        // async reset, released away from the rising edge
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            maybe_gap();
            offer_item(directed_rows[i]);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i >= RANDOM_ITEMS - QUIET_ITEMS)
                no_gaps = 1'b1;
            maybe_gap();
            it = make_random_item();
            offer_item(it);
        end
        @(negedge clk) push <= 1'b0;

        // watchdog bounds this wait
        while (draws_due.size() != 0)
            @(posedge clk);
        // catch any stray result after the last expected one
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
